// ===== design/dqne_pkg.sv =====
// ---------------------------------------------------------------------------
// DNS query name extractor package
// Shared types and constants for the question-name extractor.
// ---------------------------------------------------------------------------
package dqne_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_LEN,
        PH_LABEL,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LENGTH = 3'd1,
        ST_NOT_QUERY  = 3'd2,
        ST_LABEL_LONG = 3'd3,
        ST_NAME_LONG  = 3'd4,
        ST_TRUNCATED  = 3'd5,
        ST_NO_TERM    = 3'd6
    } status_t;

    typedef enum logic {
        REG_MAX_LABEL_LENGTH = 1'b0,
        REG_MAX_NAME_LENGTH  = 1'b1
    } cfg_reg_t;

    localparam int CFG_DATA_W = 10;

    localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
    localparam logic [16:0] HDR_LAST_UDP   = 17'd11;
    localparam logic [16:0] HDR_LAST_TCP   = 17'd13;
    localparam logic [16:0] PREFIX_LEN     = 17'd2;
    localparam logic [16:0] HDR_LEN_UDP    = 17'd12;
    localparam logic [15:0] MIN_MSG_LEN    = 16'd12;
    localparam logic [17:0] TERM_TAIL      = 18'd3;
    localparam logic [7:0]  DOT_CHAR       = 8'h2E;
    localparam logic [7:0]  MAX_LABEL_RST  = 8'd63;
    localparam logic [9:0]  MAX_NAME_RST   = 10'd256;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] name_char;
        logic       char_valid;
        logic       done_res;
        status_t    status;
        logic [9:0] name_length;
    } result_t;

endpackage

// ===== design/dqne_if.sv =====
// ---------------------------------------------------------------------------
// DNS query name extractor channels
// Valid/ready channels for payload bytes and for name results.
// ---------------------------------------------------------------------------
interface dqne_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       tcp_framing;

    modport source (output valid, data_byte, first_byte, last_byte, tcp_framing,
                    input ready);
    modport sink (input valid, data_byte, first_byte, last_byte, tcp_framing,
                  output ready);
endinterface

interface dqne_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       char_valid;
    logic       done_res;
    logic [2:0] status;
    logic [9:0] name_length;

    modport source (output valid, name_char, char_valid, done_res, status, name_length,
                    input ready);
    modport sink (input valid, name_char, char_valid, done_res, status, name_length,
                  output ready);
endinterface

// ===== design/dqne_core.sv =====
// ---------------------------------------------------------------------------
// DNS query name extractor parse core
// Registers one payload byte, walks header and labels, and produces up to
// two results for the output queue.
// ---------------------------------------------------------------------------
module dqne_core
    import dqne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dqne_in_if.sink     in_ch,
    input  logic [7:0]  max_label_length,
    input  logic [9:0]  max_name_length,
    input  logic        room,
    output result_t     res0,
    output result_t     res1,
    output logic [1:0]  push_cnt
);

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  data_reg;
    logic        first_reg, last_reg, tcp_reg;

    phase_t      phase_reg, n_phase, c_phase;
    logic [16:0] bc_reg, n_bc, c_bc;
    logic [15:0] ml_reg, n_ml, c_ml;
    logic [4:0]  flags_reg, n_flags, c_flags;
    logic [15:0] qc_reg, n_qc, c_qc;
    logic [7:0]  lr_reg, n_lr, c_lr;
    logic [9:0]  nc_reg, n_nc, c_nc;
    logic        term_reg, n_term, c_term;
    status_t     err_reg, n_err, c_err;
    logic        tcp_mode_reg, c_tcp;

    logic        load, proc_fire, active;
    logic [16:0] hdr_base, hdr_last;
    logic        dot;
    logic [10:0] name_need;
    logic        char_emit;
    logic [7:0]  char_val;
    status_t     fin_status;

    assign proc_fire   = in_vld_reg && room;
    assign in_ch.ready = !in_vld_reg || proc_fire;
    assign load        = in_ch.valid && in_ch.ready;
    assign active      = first_reg || (phase_reg != PH_IDLE);

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (load)
        begin
            in_vld_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        c_phase = first_reg ? PH_HDR : phase_reg;
        c_bc    = first_reg ? '0 : bc_reg;
        c_ml    = first_reg ? '0 : ml_reg;
        c_flags = first_reg ? '0 : flags_reg;
        c_qc    = first_reg ? '0 : qc_reg;
        c_lr    = first_reg ? '0 : lr_reg;
        c_nc    = first_reg ? '0 : nc_reg;
        c_term  = first_reg ? 1'b0 : term_reg;
        c_err   = first_reg ? ST_OK : err_reg;
        c_tcp   = first_reg ? tcp_reg : tcp_mode_reg;
    end

    always_comb
    begin
        n_phase   = c_phase;
        n_bc      = (c_bc != COUNT_MAX) ? c_bc + 17'd1 : c_bc;
        n_ml      = c_ml;
        n_flags   = c_flags;
        n_qc      = c_qc;
        n_lr      = c_lr;
        n_nc      = c_nc;
        n_term    = c_term;
        n_err     = c_err;
        char_emit = 1'b0;
        char_val  = data_reg;
        hdr_base  = c_tcp ? PREFIX_LEN : 17'd0;
        hdr_last  = c_tcp ? HDR_LAST_TCP : HDR_LAST_UDP;
        dot       = (c_nc != 10'd0);
        name_need = {1'b0, c_nc} + {10'd0, dot} + {3'd0, data_reg};

        unique case (c_phase)
            PH_HDR:
            begin
                if (c_tcp && c_bc == 17'd0)
                begin
                    n_ml = {data_reg, 8'd0};
                end
                else if (c_tcp && c_bc == 17'd1)
                begin
                    n_ml = {c_ml[15:8], data_reg};
                end
                else if (c_bc == hdr_base + 17'd2)
                begin
                    n_flags = data_reg[7:3];
                end
                else if (c_bc == hdr_base + 17'd4)
                begin
                    n_qc = {data_reg, 8'd0};
                end
                else if (c_bc == hdr_base + 17'd5)
                begin
                    n_qc = {c_qc[15:8], data_reg};
                end
                if (c_bc == hdr_last)
                begin
                    if (n_qc != 16'd1 || (c_tcp && n_flags != 5'd0))
                    begin
                        n_err   = ST_NOT_QUERY;
                        n_phase = PH_SKIP;
                    end
                    else
                    begin
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_LEN, PH_LABEL:
            begin
                if (c_tcp && {1'b0, c_bc} >= {2'd0, c_ml} + 18'd2)
                begin
                    n_phase = PH_SKIP;
                end
                else if (c_phase == PH_LABEL)
                begin
                    char_emit = 1'b1;
                    n_nc      = c_nc + 10'd1;
                    n_lr      = c_lr - 8'd1;
                    if (c_lr == 8'd1)
                    begin
                        n_phase = PH_LEN;
                    end
                end
                else if (data_reg == 8'd0)
                begin
                    n_term  = 1'b1;
                    n_phase = PH_SKIP;
                    if (c_tcp && {1'b0, c_bc} + TERM_TAIL > {2'd0, c_ml})
                    begin
                        n_err = ST_TRUNCATED;
                    end
                end
                else if (data_reg > max_label_length)
                begin
                    n_err   = ST_LABEL_LONG;
                    n_phase = PH_SKIP;
                end
                else if (name_need >= {1'b0, max_name_length})
                begin
                    n_err   = ST_NAME_LONG;
                    n_phase = PH_SKIP;
                end
                else if (c_tcp && {1'b0, c_bc} + {10'd0, data_reg} > {2'd0, c_ml} + 18'd1)
                begin
                    n_err   = ST_TRUNCATED;
                    n_phase = PH_SKIP;
                end
                else
                begin
                    if (dot)
                    begin
                        char_emit = 1'b1;
                        char_val  = DOT_CHAR;
                        n_nc      = c_nc + 10'd1;
                    end
                    n_lr    = data_reg;
                    n_phase = PH_LABEL;
                end
            end
            default:
            begin
                n_phase = c_phase;
            end
        endcase

        if (c_tcp)
        begin
            if (n_bc < PREFIX_LEN || n_ml < MIN_MSG_LEN
                || {2'd0, n_ml} + 18'd2 > {1'b0, n_bc})
            begin
                fin_status = ST_BAD_LENGTH;
            end
            else if (n_err != ST_OK)
            begin
                fin_status = n_err;
            end
            else
            begin
                fin_status = n_term ? ST_OK : ST_NO_TERM;
            end
        end
        else
        begin
            if (n_bc <= HDR_LEN_UDP || (n_bc - HDR_LEN_UDP) > {7'd0, max_name_length})
            begin
                fin_status = ST_BAD_LENGTH;
            end
            else if (n_err != ST_OK)
            begin
                fin_status = n_err;
            end
            else
            begin
                fin_status = (n_phase == PH_LABEL) ? ST_TRUNCATED : ST_OK;
            end
        end

        if (last_reg)
        begin
            n_phase = PH_IDLE;
        end
    end

    always_comb
    begin
        result_t char_res;
        result_t done_res;
        char_res             = '0;
        char_res.name_char   = char_val;
        char_res.char_valid  = 1'b1;
        done_res             = '0;
        done_res.done_res    = 1'b1;
        done_res.status      = fin_status;
        done_res.name_length = n_nc;
        res0     = char_emit ? char_res : done_res;
        res1     = done_res;
        push_cnt = 2'd0;
        if (proc_fire && active)
        begin
            push_cnt = {1'b0, char_emit} + {1'b0, last_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg  <= in_ch.data_byte;
            first_reg <= in_ch.first_byte;
            last_reg  <= in_ch.last_byte;
            tcp_reg   <= in_ch.tcp_framing;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            phase_reg    <= PH_IDLE;
            bc_reg       <= '0;
            ml_reg       <= '0;
            flags_reg    <= '0;
            qc_reg       <= '0;
            lr_reg       <= '0;
            nc_reg       <= '0;
            term_reg     <= 1'b0;
            err_reg      <= ST_OK;
            tcp_mode_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (proc_fire && active)
            begin
                phase_reg    <= n_phase;
                bc_reg       <= n_bc;
                ml_reg       <= n_ml;
                flags_reg    <= n_flags;
                qc_reg       <= n_qc;
                lr_reg       <= n_lr;
                nc_reg       <= n_nc;
                term_reg     <= n_term;
                err_reg      <= n_err;
                tcp_mode_reg <= c_tcp;
            end
        end
    end

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> room)
        else $error("results pushed without queue room");

    a_pair_is_char_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> (res0.char_valid && res1.done_res))
        else $error("a result pair must be a name byte followed by the final result");

    a_label_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LABEL |-> lr_reg != 8'd0)
        else $error("label walk with no bytes left");

endmodule

// ===== design/dqne_out_fifo.sv =====
// ---------------------------------------------------------------------------
// DNS query name extractor result queue
// Small queue that takes up to two results per cycle and hands out one.
// ---------------------------------------------------------------------------
module dqne_out_fifo
    import dqne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  result_t     res0,
    input  result_t     res1,
    input  logic [1:0]  push_cnt,
    output logic        room,
    dqne_out_if.source  out_ch
);

    result_t              slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 pop;
    result_t              head;

    assign room = count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
    assign pop  = out_ch.valid && out_ch.ready;
    assign head = slot_reg[rd_ptr_reg];

    assign out_ch.valid       = count_reg != '0;
    assign out_ch.name_char   = head.name_char;
    assign out_ch.char_valid  = head.char_valid;
    assign out_ch.done_res    = head.done_res;
    assign out_ch.status      = head.status;
    assign out_ch.name_length = head.name_length;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            slot_reg[wr_ptr_reg + FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_pop_only_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_cnt == 2'd0) |=> count_reg == $past(count_reg) - (FIFO_AW+1)'(1))
        else $error("queue count wrong after a pop");

    a_ptr_gap_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != (FIFO_AW+1)'(FIFO_DEPTH)
        |-> FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ===== design/dns_query_name_extractor.sv =====
// A result passes the input register, then the result queue, on its way out.
// Throughput: one item per cycle while the result queue has room; an item that
// yields a name byte and the final result pushes both into the four-entry result queue.
// The label walk steps one byte at a time through the parse state and one byte register.
// Reset clears the walk state and the queue and loads max_label_length 63 and
// max_name_length 256.
// ---------------------------------------------------------------------------
// DNS query name extractor
// Extracts the dotted question name from a DNS message, one payload byte per item.
// ---------------------------------------------------------------------------
module dns_query_name_extractor
    import dqne_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dqne_in_if.sink               in_ch,
    dqne_out_if.source            out_ch
);

    logic [7:0] max_label_length_reg;
    logic [9:0] max_name_length_reg;
    result_t    res0, res1;
    logic [1:0] push_cnt;
    logic       room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_label_length_reg <= MAX_LABEL_RST;
            max_name_length_reg  <= MAX_NAME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_LABEL_LENGTH: max_label_length_reg <= cfg_data[7:0];
                REG_MAX_NAME_LENGTH:  max_name_length_reg  <= cfg_data[9:0];
                default:              max_name_length_reg  <= max_name_length_reg;
            endcase
        end
    end

    dqne_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ch            (in_ch),
        .max_label_length (max_label_length_reg),
        .max_name_length  (max_name_length_reg),
        .room             (room),
        .res0             (res0),
        .res1             (res1),
        .push_cnt         (push_cnt)
    );

    dqne_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .res0     (res0),
        .res1     (res1),
        .push_cnt (push_cnt),
        .room     (room),
        .out_ch   (out_ch)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// DNS query name extractor testbench
// Feeds DNS messages in UDP and TCP framing one byte per item, predicts the
// dotted question name and the final status of each message, and checks
// every result item in order under several register settings and idling
// patterns on both channels.
// ---------------------------------------------------------------------------
module tb_top;
    import dqne_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       is_first;
        logic       is_last;
        logic       tcp;
    } payload_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dqne_in_if  in_ch ();
    dqne_out_if out_ch ();

    dns_query_name_extractor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    payload_byte_t payload_q[$];
    result_t       expected_names[$];
    int            queued;
    int            errors;
    int            idle_pct;
    int            stall_pct;
    logic          in_took;

    logic [7:0]  label_limit;
    logic [9:0]  name_limit;

    phase_t      walk_phase;
    logic [16:0] walk_count;
    logic [15:0] walk_msg_len;
    logic [15:0] walk_flags;
    logic [15:0] walk_qdcount;
    logic [7:0]  walk_left;
    logic [9:0]  walk_name_len;
    logic        walk_term;
    status_t     walk_err;
    logic        walk_tcp;

    always #6 clk = ~clk;

    function automatic void clear_walk();
        walk_phase    = PH_IDLE;
        walk_count    = '0;
        walk_msg_len  = '0;
        walk_flags    = '0;
        walk_qdcount  = '0;
        walk_left     = '0;
        walk_name_len = '0;
        walk_term     = 1'b0;
        walk_err      = ST_OK;
        walk_tcp      = 1'b0;
    endfunction

    function automatic void push_name_char(logic [7:0] ch);
        result_t r;
        r.name_char   = ch;
        r.char_valid  = 1'b1;
        r.done_res    = 1'b0;
        r.status      = ST_OK;
        r.name_length = '0;
        expected_names.push_back(r);
        walk_name_len++;
    endfunction

    function automatic status_t final_code();
        if (walk_tcp) begin
            if (walk_count < 2 || walk_msg_len < MIN_MSG_LEN ||
                int'(walk_msg_len) + 2 > int'(walk_count))
                return ST_BAD_LENGTH;
        end else if (walk_count <= 12 || int'(walk_count) - 12 > int'(name_limit)) begin
            return ST_BAD_LENGTH;
        end
        if (walk_err != ST_OK)
            return walk_err;
        if (walk_tcp)
            return walk_term ? ST_OK : ST_NO_TERM;
        return (walk_phase == PH_LABEL) ? ST_TRUNCATED : ST_OK;
    endfunction

    function automatic void parse_payload_byte(logic [7:0] v, logic is_first, logic is_last,
                                               logic tcp);
        int      pos;
        int      hdr_end;
        int      base;
        int      msg_len;
        int      off;
        int      dot;
        result_t r;
        if (is_first) begin
            clear_walk();
            walk_tcp   = tcp;
            walk_phase = PH_HDR;
        end else if (walk_phase == PH_IDLE) begin
            return;
        end
        pos = int'(walk_count);
        if (walk_count < COUNT_MAX)
            walk_count++;
        hdr_end = walk_tcp ? 14 : 12;
        base    = walk_tcp ? 2 : 0;
        msg_len = int'(walk_msg_len) - 12;
        off     = pos - hdr_end;
        if (walk_phase == PH_HDR) begin
            if (walk_tcp && pos == 0)
                walk_msg_len = {v, 8'h00};
            else if (walk_tcp && pos == 1)
                walk_msg_len[7:0] = v;
            else if (pos == base + 2)
                walk_flags = {v, 8'h00};
            else if (pos == base + 3)
                walk_flags[7:0] = v;
            else if (pos == base + 4)
                walk_qdcount = {v, 8'h00};
            else if (pos == base + 5)
                walk_qdcount[7:0] = v;
            if (pos + 1 == hdr_end) begin
                if (walk_qdcount != 16'd1 ||
                    (walk_tcp && (walk_flags[15] || walk_flags[14:11] != 4'd0))) begin
                    walk_err   = ST_NOT_QUERY;
                    walk_phase = PH_SKIP;
                end else begin
                    walk_phase = PH_LEN;
                end
            end
        end else if (walk_phase == PH_LEN || walk_phase == PH_LABEL) begin
            if (walk_tcp && off >= msg_len) begin
                walk_phase = PH_SKIP;
            end else if (walk_phase == PH_LABEL) begin
                push_name_char(v);
                walk_left--;
                if (walk_left == 0)
                    walk_phase = PH_LEN;
            end else if (v == 8'd0) begin
                walk_term  = 1'b1;
                walk_phase = PH_SKIP;
                if (walk_tcp && off + 5 > msg_len)
                    walk_err = ST_TRUNCATED;
            end else if (v > label_limit) begin
                walk_err   = ST_LABEL_LONG;
                walk_phase = PH_SKIP;
            end else begin
                dot = (walk_name_len > 0) ? 1 : 0;
                if (int'(walk_name_len) + dot + int'(v) >= int'(name_limit)) begin
                    walk_err   = ST_NAME_LONG;
                    walk_phase = PH_SKIP;
                end else if (walk_tcp && off + 1 + int'(v) > msg_len) begin
                    walk_err   = ST_TRUNCATED;
                    walk_phase = PH_SKIP;
                end else begin
                    if (dot != 0)
                        push_name_char(DOT_CHAR);
                    walk_left  = v;
                    walk_phase = PH_LABEL;
                end
            end
        end
        if (is_last) begin
            r.name_char   = '0;
            r.char_valid  = 1'b0;
            r.done_res    = 1'b1;
            r.status      = final_code();
            r.name_length = walk_name_len;
            expected_names.push_back(r);
            walk_phase = PH_IDLE;
        end
    endfunction

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    function automatic void push_byte(logic [7:0] d, logic is_first, logic is_last, logic tcp);
        payload_byte_t b;
        b.data     = d;
        b.is_first = is_first;
        b.is_last  = is_last;
        b.tcp      = is_first ? tcp : 1'($urandom_range(1));
        payload_q.push_back(b);
        queued++;
    endfunction

    // Mostly well-formed queries; a faulty one carries one of several defects.
    function automatic void queue_query(bit clean);
        logic [7:0]  frame[$];
        logic [15:0] flags;
        logic [15:0] qd;
        logic [15:0] plen;
        int          fault;
        int          n_lab;
        int          len;
        int          keep;
        int          i;
        int          j;
        bit          tcp;
        fault = clean ? -1 : int'($urandom_range(7));
        tcp   = 1'($urandom_range(1));
        flags = {5'b00000, 11'($urandom)};
        qd    = 16'd1;
        if (fault == 0)
            flags[15] = 1'b1;
        if (fault == 1)
            flags[14:11] = 4'($urandom_range(15, 1));
        if (fault == 2)
            qd = ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom_range(65535, 2));
        if ($urandom_range(9) == 0)
            push_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), 1'b0);
        repeat (2) frame.push_back(8'($urandom));
        frame.push_back(flags[15:8]);
        frame.push_back(flags[7:0]);
        frame.push_back(qd[15:8]);
        frame.push_back(qd[7:0]);
        repeat (6) frame.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
        n_lab = $urandom_range(4);
        for (i = 0; i < n_lab; i++) begin
            case ($urandom_range(19))
                0:       len = $urandom_range(255, 1);
                1, 2:    len = $urandom_range(label_limit, 1);
                default: len = $urandom_range((label_limit < 6) ? label_limit : 6, 1);
            endcase
            if (fault == 7 && i == n_lab - 1 && label_limit < 8'd255)
                len = $urandom_range(255, int'(label_limit) + 1);
            frame.push_back(8'(len));
            for (j = 0; j < len; j++)
                frame.push_back(8'($urandom));
        end
        if (fault != 3)
            frame.push_back(8'h00);
        repeat (4) frame.push_back(8'($urandom));
        repeat ($urandom_range(2)) frame.push_back(8'($urandom));
        if (fault == 4) begin
            keep = $urandom_range(frame.size(), 1);
            while (frame.size() > keep)
                void'(frame.pop_back());
        end
        plen = 16'(frame.size());
        if (fault == 6) begin
            case ($urandom_range(2))
                0:       plen = 16'($urandom_range(11));
                1:       plen = 16'(frame.size() + $urandom_range(8, 1));
                default: plen = 16'($urandom_range(frame.size()));
            endcase
        end
        if (tcp) begin
            frame.push_front(plen[7:0]);
            frame.push_front(plen[15:8]);
        end
        for (i = 0; i < frame.size(); i++)
            push_byte(frame[i], i == 0, i == frame.size() - 1 && fault != 5, tcp);
    endfunction

    task automatic drain();
        do
            @(negedge clk);
        while (payload_q.size() != 0 || in_ch.valid || expected_names.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [9:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_MAX_LABEL_LENGTH)
            label_limit = val[7:0];
        else
            name_limit = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [7:0] lbl, logic [9:0] nm, int idle, int stall, int n_bytes);
        int start;
        drain();
        write_reg(REG_MAX_LABEL_LENGTH, {2'b00, lbl});
        write_reg(REG_MAX_NAME_LENGTH, nm);
        idle_pct  = idle;
        stall_pct = stall;
        start     = queued;
        while (queued - start < n_bytes / 2)
            queue_query($urandom_range(99) < 75);
        drain();
        while (queued - start < n_bytes)
            queue_query($urandom_range(99) < 75);
        queue_query(1'b1);
    endtask

    always @(negedge clk) begin : drive
        payload_byte_t b;
        if (!in_ch.valid || in_took) begin
            if (payload_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                b = payload_q.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.data_byte   <= b.data;
                in_ch.first_byte  <= b.is_first;
                in_ch.last_byte   <= b.is_last;
                in_ch.tcp_framing <= b.tcp;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin : watch
        result_t want;
        in_took <= in_ch.valid && in_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_names.size() == 0) begin
                flag_error($sformatf("unexpected result: char %02h cv %0b done %0b st %0d len %0d",
                                     out_ch.name_char, out_ch.char_valid, out_ch.done_res,
                                     out_ch.status, out_ch.name_length));
            end else begin
                want = expected_names.pop_front();
                if (out_ch.name_char !== want.name_char || out_ch.char_valid !== want.char_valid ||
                    out_ch.done_res !== want.done_res || out_ch.status !== want.status ||
                    out_ch.name_length !== want.name_length)
                    flag_error($sformatf({"result mismatch: expected char %02h cv %0b done %0b",
                                          " st %0d len %0d, got char %02h cv %0b done %0b",
                                          " st %0d len %0d"},
                                         want.name_char, want.char_valid, want.done_res,
                                         want.status, want.name_length, out_ch.name_char,
                                         out_ch.char_valid, out_ch.done_res, out_ch.status,
                                         out_ch.name_length));
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
            parse_payload_byte(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte,
                               in_ch.tcp_framing);
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [7:0] lead[$];
        int         i;
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_MAX_LABEL_LENGTH;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.first_byte  = 1'b0;
        in_ch.last_byte   = 1'b0;
        in_ch.tcp_framing = 1'b0;
        out_ch.ready      = 1'b0;
        in_took           = 1'b0;
        queued            = 0;
        errors            = 0;
        idle_pct          = 0;
        stall_pct         = 0;
        label_limit       = MAX_LABEL_RST;
        name_limit        = MAX_NAME_RST;
        clear_walk();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Stray bytes, one-byte messages, a dropped message and a short UDP query.
        push_byte(8'hFF, 1'b0, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b1);
        push_byte(8'hA5, 1'b1, 1'b1, 1'b0);
        push_byte(8'h5A, 1'b1, 1'b1, 1'b1);
        push_byte(8'h00, 1'b1, 1'b0, 1'b1);
        push_byte(8'h0C, 1'b0, 1'b0, 1'b1);
        lead = '{8'h12, 8'h34, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h02, 8'h80, 8'h7F, 8'h00};
        for (i = 0; i < lead.size(); i++)
            push_byte(lead[i], i == 0, i == lead.size() - 1, 1'b0);

        run_phase(MAX_LABEL_RST, MAX_NAME_RST, 0, 0, 40);

        // A TCP query followed by trailing bytes past its prefixed length.
        drain();
        lead = '{8'h00, 8'h13, 8'hAB, 8'hCD, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h61, 8'h00, 8'h00, 8'h01, 8'h00,
                 8'h01};
        for (i = 0; i < lead.size() + 8; i++)
            push_byte((i < lead.size()) ? lead[i] : 8'($urandom), i == 0,
                      i == lead.size() + 7, 1'b1);

        run_phase(8'd255, 10'd1023, 79, 0, 40);
        run_phase(8'd1, 10'd1, 0, 79, 24);
        run_phase(8'd8, 10'd24, 0, 79, 40);
        run_phase(8'($urandom_range(255, 1)), 10'($urandom_range(1023, 1)), 7, 7, 40);
        run_phase(8'($urandom_range(20, 2)), 10'($urandom_range(80, 10)), 7, 7, 40);
        drain();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
design/dqne_pkg.sv
design/dqne_if.sv
design/dqne_core.sv
design/dqne_out_fifo.sv
design/dns_query_name_extractor.sv
tb/tb_top.sv
